// ===== hw/rtl/tfpp_pkg.sv =====
// Shared types, codes and constants for the tagged field packet parser.
`timescale 1ns / 1ps

package tfpp_pkg;

    // Fixed header layout.
    localparam int HEADER_BYTES = 4;
    localparam int ID_OFFSET    = 2;

    // Stream widths and result tdata layout.
    localparam int S_TDATA_W   = 8;
    localparam int VALUE_W     = 64;
    localparam int COUNT_W     = 16;
    localparam int KIND_W      = 3;
    localparam int STATUS_W    = 2;
    localparam int VALUE_LSB   = 0;
    localparam int COUNT_LSB   = VALUE_LSB + VALUE_W;
    localparam int ELAST_BIT   = COUNT_LSB + COUNT_W;
    localparam int STATUS_LSB  = ELAST_BIT + 1;
    localparam int M_FIELDS_W  = STATUS_LSB + STATUS_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W     = M_TDATA_W - M_FIELDS_W;

    // Field tags.
    localparam logic [7:0] TAG_U16       = 8'd1;
    localparam logic [7:0] TAG_DOUBLE    = 8'd2;
    localparam logic [7:0] TAG_STRING    = 8'd3;
    localparam logic [7:0] TAG_U16_ARRAY = 8'd4;
    localparam logic [7:0] TAG_DBL_ARRAY = 8'd5;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_TAG     = 3'd1,
        PH_SCALAR  = 3'd2,
        PH_COUNT   = 3'd3,
        PH_ELEMS   = 3'd4,
        PH_DISCARD = 3'd5
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_STATUS     = 3'd0,
        KIND_PACKET_ID  = 3'd1,
        KIND_U16        = 3'd2,
        KIND_DOUBLE     = 3'd3,
        KIND_STR_BYTE   = 3'd4,
        KIND_U16_ELEM   = 3'd5,
        KIND_DBL_ELEM   = 3'd6
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_UNKNOWN_TAG = 2'd1,
        ST_TRUNCATED   = 2'd2
    } status_t;

    typedef struct packed {
        kind_t                kind;
        logic [VALUE_W-1:0]   value;
        logic [COUNT_W-1:0]   count;
        logic                 elast;
        logic                 pend;
        status_t              status;
    } result_t;

    // Element size in bytes for a field tag.
    function automatic logic [3:0] elem_size(input logic [2:0] tag);
        logic [3:0] size;
        case (tag)
            3'd1:    size = 4'd2;
            3'd2:    size = 4'd8;
            3'd3:    size = 4'd1;
            3'd4:    size = 4'd2;
            default: size = 4'd8;
        endcase
        return size;
    endfunction

    // Status-only result that closes the packet.
    function automatic result_t end_result(input status_t st);
        result_t r;
        r        = '0;
        r.kind   = KIND_STATUS;
        r.pend   = 1'b1;
        r.status = st;
        return r;
    endfunction

endpackage

// ===== hw/rtl/tagged_field_packet_parser.sv =====
// Top level of the tagged field packet parser: byte stream in, parsed results out.
`timescale 1ns / 1ps

// Parses one packet byte per accepted input item (s_tdata = byte, s_tlast on
// the final byte). The first HEADER_BYTES bytes form a header whose
// little-endian u16 at ID_OFFSET is reported as the packet id; tagged
// little-endian fields follow (tag 1 u16, tag 2 double bits, tags 3/4/5 a u16
// count then bytes, u16 words or doubles, one result per element). Each
// input item yields zero or one result item. An unknown tag or a packet that
// ends inside a field closes the packet with an error status and drops the
// rest of it. The parse state machine and byte-lane shift register update on
// the edge that accepts the item, and its result is registered into the output
// register (or the skid entry), so one item per cycle is sustained while s_tready is high.
// A two-entry output (register plus skid) lets the input keep flowing while a
// result waits; s_tready drops only while the skid entry is occupied.
module tagged_field_packet_parser (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: [7:0] data_byte
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tfpp_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tlast,      // last_byte
    // m_tdata: [63:0] value, [79:64] count, [80] element_last,
    //          [82:81] status, [87:83] zero
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tfpp_pkg::M_TDATA_W-1:0]  m_tdata,
    // m_tuser: [2:0] kind
    output logic [tfpp_pkg::KIND_W-1:0]     m_tuser,
    output logic                            m_tlast       // packet_end
);

    localparam logic [3:0] ID_IDX   = 4'(tfpp_pkg::ID_OFFSET);
    localparam logic [4:0] HDR_LEN  = 5'(tfpp_pkg::HEADER_BYTES);

    // Parse state.
    tfpp_pkg::phase_t   phase_reg, phase_next;
    logic [3:0]         byte_index_reg, byte_index_next;
    logic [2:0]         field_tag_reg, field_tag_next;
    logic [63:0]        assembly_reg, assembly_next;
    logic [15:0]        element_count_reg, element_count_next;
    logic [15:0]        elements_left_reg, elements_left_next;
    tfpp_pkg::status_t  error_code_reg, error_code_next;

    // Output register and skid entry.
    tfpp_pkg::result_t  out_reg, skid_reg;
    logic               out_valid_reg, skid_valid_reg;

    tfpp_pkg::result_t  res;
    logic               res_valid;

    logic               in_accept;
    logic               out_free;
    logic [7:0]         b;
    logic [3:0]         idx_inc;
    logic [3:0]         id_lane;
    logic [63:0]        lane_byte;
    logic [63:0]        asm_shift;

    assign s_tready  = !skid_valid_reg;
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    assign b         = s_tdata[7:0];
    assign idx_inc   = byte_index_reg + 4'd1;
    assign id_lane   = byte_index_reg - ID_IDX;
    assign lane_byte = {56'd0, b};
    // Byte lane for little-endian assembly of field values.
    assign asm_shift = assembly_reg | (lane_byte << {byte_index_reg[2:0], 3'b000});

    // Next state and result for the byte at the input.
    always_comb begin
        phase_next         = phase_reg;
        byte_index_next    = byte_index_reg;
        field_tag_next     = field_tag_reg;
        assembly_next      = assembly_reg;
        element_count_next = element_count_reg;
        elements_left_next = elements_left_reg;
        error_code_next    = error_code_reg;
        res                = '0;
        res_valid          = 1'b0;

        case (phase_reg)
            tfpp_pkg::PH_TAG: begin
                if (b >= tfpp_pkg::TAG_U16 && b <= tfpp_pkg::TAG_DBL_ARRAY) begin
                    field_tag_next  = b[2:0];
                    byte_index_next = 4'd0;
                    assembly_next   = '0;
                    phase_next      = (b <= tfpp_pkg::TAG_DOUBLE) ? tfpp_pkg::PH_SCALAR
                                                                   : tfpp_pkg::PH_COUNT;
                    if (s_tlast) begin
                        res       = tfpp_pkg::end_result(tfpp_pkg::ST_TRUNCATED);
                        res_valid = 1'b1;
                    end
                end else if (s_tlast) begin
                    res       = tfpp_pkg::end_result(tfpp_pkg::ST_UNKNOWN_TAG);
                    res_valid = 1'b1;
                end else begin
                    // Latch the error and drop the rest of the packet.
                    error_code_next = tfpp_pkg::ST_UNKNOWN_TAG;
                    phase_next      = tfpp_pkg::PH_DISCARD;
                end
            end

            tfpp_pkg::PH_SCALAR: begin
                assembly_next   = asm_shift;
                byte_index_next = idx_inc;
                if (idx_inc >= tfpp_pkg::elem_size(field_tag_reg)) begin
                    res.kind        = (field_tag_reg == 3'd1) ? tfpp_pkg::KIND_U16
                                                              : tfpp_pkg::KIND_DOUBLE;
                    res.value       = asm_shift;
                    res.elast       = 1'b1;
                    res.pend        = s_tlast;
                    res.status      = tfpp_pkg::ST_OK;
                    res_valid       = 1'b1;
                    phase_next      = tfpp_pkg::PH_TAG;
                    byte_index_next = 4'd0;
                    assembly_next   = '0;
                end else if (s_tlast) begin
                    res       = tfpp_pkg::end_result(tfpp_pkg::ST_TRUNCATED);
                    res_valid = 1'b1;
                end
            end

            tfpp_pkg::PH_COUNT: begin
                assembly_next   = asm_shift;
                byte_index_next = idx_inc;
                if (idx_inc >= 4'd2) begin
                    element_count_next = asm_shift[15:0];
                    elements_left_next = asm_shift[15:0];
                    byte_index_next    = 4'd0;
                    assembly_next      = '0;
                    if (asm_shift[15:0] == 16'd0) begin
                        // Empty field: one result of its kind, no elements.
                        phase_next = tfpp_pkg::PH_TAG;
                        res.kind   = tfpp_pkg::kind_t'(field_tag_reg + 3'd1);
                        res.elast  = 1'b1;
                        res.pend   = s_tlast;
                        res.status = tfpp_pkg::ST_OK;
                        res_valid  = 1'b1;
                    end else begin
                        phase_next = tfpp_pkg::PH_ELEMS;
                        if (s_tlast) begin
                            res       = tfpp_pkg::end_result(tfpp_pkg::ST_TRUNCATED);
                            res_valid = 1'b1;
                        end
                    end
                end else if (s_tlast) begin
                    res       = tfpp_pkg::end_result(tfpp_pkg::ST_TRUNCATED);
                    res_valid = 1'b1;
                end
            end

            tfpp_pkg::PH_ELEMS: begin
                assembly_next   = asm_shift;
                byte_index_next = idx_inc;
                if (idx_inc >= tfpp_pkg::elem_size(field_tag_reg)) begin
                    byte_index_next    = 4'd0;
                    assembly_next      = '0;
                    elements_left_next = elements_left_reg - 16'd1;
                    res_valid          = 1'b1;
                    if (elements_left_reg <= 16'd1) begin
                        phase_next = tfpp_pkg::PH_TAG;
                        res.kind   = tfpp_pkg::kind_t'(field_tag_reg + 3'd1);
                        res.value  = asm_shift;
                        res.count  = element_count_reg;
                        res.elast  = 1'b1;
                        res.pend   = s_tlast;
                        res.status = tfpp_pkg::ST_OK;
                    end else if (s_tlast) begin
                        // Elements still owed: the packet end wins.
                        res = tfpp_pkg::end_result(tfpp_pkg::ST_TRUNCATED);
                    end else begin
                        res.kind   = tfpp_pkg::kind_t'(field_tag_reg + 3'd1);
                        res.value  = asm_shift;
                        res.count  = element_count_reg;
                        res.status = tfpp_pkg::ST_OK;
                    end
                end else if (s_tlast) begin
                    res       = tfpp_pkg::end_result(tfpp_pkg::ST_TRUNCATED);
                    res_valid = 1'b1;
                end
            end

            tfpp_pkg::PH_DISCARD: begin
                if (s_tlast) begin
                    res       = tfpp_pkg::end_result(error_code_reg);
                    res_valid = 1'b1;
                end
            end

            default: begin
                // Header phase, also taken by unused phase codes.
                if (byte_index_reg >= ID_IDX && id_lane < 4'd2) begin
                    assembly_next = assembly_reg | (lane_byte << {id_lane[0], 3'b000});
                end
                if ({1'b0, byte_index_reg} + 5'd1 >= HDR_LEN) begin
                    res.kind        = tfpp_pkg::KIND_PACKET_ID;
                    res.value       = {48'd0, assembly_next[15:0]};
                    res.pend        = s_tlast;
                    res.status      = tfpp_pkg::ST_OK;
                    res_valid       = 1'b1;
                    phase_next      = tfpp_pkg::PH_TAG;
                    byte_index_next = 4'd0;
                    assembly_next   = '0;
                end else begin
                    byte_index_next = idx_inc;
                    if (s_tlast) begin
                        res       = tfpp_pkg::end_result(tfpp_pkg::ST_TRUNCATED);
                        res_valid = 1'b1;
                    end
                end
            end
        endcase

        // Packet closed: return to the reset state.
        if (res_valid && res.pend) begin
            phase_next         = tfpp_pkg::PH_HEADER;
            byte_index_next    = 4'd0;
            field_tag_next     = 3'd0;
            assembly_next      = '0;
            element_count_next = 16'd0;
            elements_left_next = 16'd0;
            error_code_next    = tfpp_pkg::ST_OK;
        end
    end

    // Parse state registers: advance only on an accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= tfpp_pkg::PH_HEADER;
            byte_index_reg    <= 4'd0;
            field_tag_reg     <= 3'd0;
            assembly_reg      <= '0;
            element_count_reg <= 16'd0;
            elements_left_reg <= 16'd0;
            error_code_reg    <= tfpp_pkg::ST_OK;
        end else if (in_accept) begin
            phase_reg         <= phase_next;
            byte_index_reg    <= byte_index_next;
            field_tag_reg     <= field_tag_next;
            assembly_reg      <= assembly_next;
            element_count_reg <= element_count_next;
            elements_left_reg <= elements_left_next;
            error_code_reg    <= error_code_next;
        end
    end

    // Output register with skid entry. While the skid holds an item no new
    // input is taken, so at most one of skid refill and new result applies.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (out_free) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end else if (in_accept && res_valid) begin
                if (out_free) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (out_free) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_free) begin
                out_reg <= skid_reg;
            end
        end else if (in_accept && res_valid) begin
            if (out_free) begin
                out_reg <= res;
            end else begin
                skid_reg <= res;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.pend;
    assign m_tdata  = {{tfpp_pkg::M_PAD_W{1'b0}}, out_reg.status, out_reg.elast,
                       out_reg.count, out_reg.value};

endmodule

// ===== hw/rtl/tfpp_checker.sv =====
// Port-level assertions for the tagged field packet parser, with its bind.
`timescale 1ns / 1ps

module tfpp_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [tfpp_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic [tfpp_pkg::KIND_W-1:0]     m_tuser,
    input  logic                            m_tlast
);

    logic [tfpp_pkg::STATUS_W-1:0] m_status;
    logic [tfpp_pkg::COUNT_W-1:0]  m_count;
    logic                          m_elast;

    assign m_status = m_tdata[tfpp_pkg::STATUS_LSB +: tfpp_pkg::STATUS_W];
    assign m_count  = m_tdata[tfpp_pkg::COUNT_LSB +: tfpp_pkg::COUNT_W];
    assign m_elast  = m_tdata[tfpp_pkg::ELAST_BIT];

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // A status-only result always closes the packet.
    a_status_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == tfpp_pkg::KIND_STATUS |-> m_tlast)
        else $error("status-only result without packet end");

    // An error status appears only on a status-only packet end.
    a_error_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_status != tfpp_pkg::ST_OK |->
            m_tlast && m_tuser == tfpp_pkg::KIND_STATUS)
        else $error("error status on a data result");

    // The packet id carries no count and no element-last flag.
    a_id_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == tfpp_pkg::KIND_PACKET_ID |->
            !m_elast && m_count == '0)
        else $error("packet id result with element fields set");

    // No result shows right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind tagged_field_packet_parser tfpp_checker u_tfpp_checker (.*);
